/* sv/pairwise_distance_sorter_core_defines.svh */
// ----------------------------------------------------------------------------
// Pairwise distance sorter assertion macros
// Concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_DISTANCE_SORTER_CORE_DEFINES_SVH
`define PAIRWISE_DISTANCE_SORTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PDS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PDS_ASSERT(label, clk, rst_n, prop, msg)
`define PDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/pds_pkg.sv */
// ----------------------------------------------------------------------------
// Pairwise distance sorter package
// Payload types, sizing constants and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package pds_pkg;
  localparam int unsigned MaxPoints = 10;
  localparam int unsigned PairCap   = (MaxPoints * (MaxPoints - 1)) / 2;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned PairW     = $clog2(PairCap + 1);
  localparam int unsigned SqW       = 34;
  localparam int unsigned DistW     = 25;
  localparam int unsigned RadW      = 50;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]  first_index;
    logic [IdxW-1:0]  second_index;
    logic [SqW-1:0]   squared_distance;
    logic [DistW-1:0] distance_fixed;
    logic             last_pair;
  } out_item_t;

  typedef struct packed {
    logic [IdxW-1:0] lo;
    logic [IdxW-1:0] hi;
    logic [SqW-1:0]  sq;
  } pair_t;

  // true when pair a sorts ahead of pair b
  function automatic logic goes_before(pair_t a, pair_t b);
    logic r;
    if (a.sq != b.sq) r = a.sq > b.sq;
    else if (a.lo != b.lo) r = a.lo < b.lo;
    else r = a.hi < b.hi;
    return r;
  endfunction
endpackage
`default_nettype wire

/* sv/pds_sqrt.sv */
// ----------------------------------------------------------------------------
// Pairwise distance sorter square root
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pds_sqrt (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [pds_pkg::SqW-1:0]  sq_i,
  output logic                          done_o,
  output logic [pds_pkg::DistW-1:0]     root_o
);
  import pds_pkg::*;

  localparam int unsigned OpW  = SqW + 16;
  localparam int unsigned StepW = $clog2(DistW + 1);

  logic [OpW-1:0]   rem_q, rem_d;
  logic [OpW-1:0]   op_q, op_d;
  logic [DistW-1:0] root_q, root_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic [RadW-1:0]  trial;
  logic [RadW-1:0]  rem_sh;

  // restoring step: bring down two bits, try 4r+1
  always_comb begin
    rem_sh = {rem_q[RadW-3:0], op_q[OpW-1 -: 2]};
    trial  = {{(RadW-DistW-2){1'b0}}, root_q, 2'b01};
    rem_d  = rem_q;
    op_d   = op_q;
    root_d = root_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      op_d   = {sq_i, 16'd0};
      root_d = '0;
      step_d = StepW'(DistW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      op_d = {op_q[OpW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[DistW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[DistW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    op_q   <= op_d;
    root_q <= root_d;
  end

  assign done_o = busy_q && (step_q == StepW'(1));
  assign root_o = {root_q[DistW-2:0], (rem_sh >= trial)};
endmodule
`default_nettype wire

/* sv/pairwise_distance_sorter_core.sv */
// Pairwise distance sorter. Points load one per transfer into a 10-entry
// store. On the point marked last, the sequencer walks every pair (i<j)
// through one shared multiplier, a difference and a square per axis, then
// inserts the pair into a sorted table by shifting one entry per cycle (up
// to 44 shifts plus one write per insert). Emission reads one table entry
// per result (states RD and FETCH), runs the 25-bit bit-serial square root
// (ROOT) and presents the result (OUT), holding it while the receiver
// stalls. The block accepts no point while a set is being sorted or emitted;
// a one-point set emits nothing.
`default_nettype none
`include "pairwise_distance_sorter_core_defines.svh"
module pairwise_distance_sorter_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire pds_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output pds_pkg::out_item_t       out_data_o
);
  import pds_pkg::*;

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_DIFF  = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_INS   = 8'b0000_1000,
    ST_RD    = 8'b0001_0000,
    ST_ROOT  = 8'b0010_0000,
    ST_OUT   = 8'b0100_0000,
    ST_FETCH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [47:0]      pts_q [MaxPoints];
  pair_t            tbl_q [PairCap];
  logic [IdxW-1:0]  cnt_q, cnt_d, n_q, n_d;
  logic [IdxW-1:0]  i_q, i_d, j_q, j_d;
  logic [1:0]       ax_q, ax_d;
  logic [SqW-1:0]   acc_q, acc_d;
  logic [PairW-1:0] pc_q, pc_d, k_q, k_d;
  logic [16:0]      dif_q;
  logic [33:0]      prod;
  pair_t            newp, rd_q, cmp_q;
  out_item_t        out_q;
  logic             sq_start, sq_done;
  logic [DistW-1:0] root;
  logic             acc_in;
  logic             ins_shift;
  logic [47:0]      pa, pb;
  logic signed [16:0] da;

  assign acc_in     = (state_q == ST_LOAD) && in_valid_i;
  assign in_stall_o = (state_q != ST_LOAD);
  assign newp       = '{lo: i_q, hi: j_q, sq: acc_q};
  // new pair moves ahead of the registered table entry
  assign ins_shift  = (k_q != '0) && goes_before(newp, cmp_q);

  // axis difference magnitude and shared square
  always_comb begin
    pa = pts_q[i_q];
    pb = pts_q[j_q];
    case (ax_q)
      2'd0:    da = 17'(signed'(pa[47:32])) - 17'(signed'(pb[47:32]));
      2'd1:    da = 17'(signed'(pa[31:16])) - 17'(signed'(pb[31:16]));
      default: da = 17'(signed'(pa[15:0]))  - 17'(signed'(pb[15:0]));
    endcase
  end
  assign prod = 34'(dif_q) * 34'(dif_q);

  pds_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .sq_i    (rd_q.sq),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d = cnt_q; n_d = n_q; i_d = i_q; j_d = j_q; ax_d = ax_q;
    acc_d = acc_q; pc_d = pc_q; k_d = k_q;
    sq_start = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (acc_in) begin
          if (cnt_q < IdxW'(MaxPoints)) cnt_d = cnt_q + 1'b1;
          if (in_data_i.last_point) begin
            n_d = (cnt_q < IdxW'(MaxPoints)) ? cnt_q + 1'b1 : cnt_q;
            cnt_d = '0;
            i_d = '0; j_d = IdxW'(1); ax_d = '0; acc_d = '0; pc_d = '0;
            if (n_d >= IdxW'(2)) state_d = ST_DIFF;
          end
        end
      end
      ST_DIFF: state_d = ST_MUL;
      ST_MUL: begin
        acc_d = acc_q + SqW'(prod);
        if (ax_q == 2'd2) begin
          ax_d = '0; k_d = pc_q; state_d = ST_INS;
        end else begin
          ax_d = ax_q + 1'b1; state_d = ST_DIFF;
        end
      end
      ST_INS: begin
        if (ins_shift) begin
          k_d = k_q - 1'b1;
        end else begin
          pc_d = pc_q + 1'b1; acc_d = '0;
          if (j_q == n_q - 1'b1) begin
            if (i_q == n_q - IdxW'(2)) begin
              k_d = '0; state_d = ST_RD;
            end else begin
              i_d = i_q + 1'b1; j_d = i_q + IdxW'(2); state_d = ST_DIFF;
            end
          end else begin
            j_d = j_q + 1'b1; state_d = ST_DIFF;
          end
        end
      end
      ST_RD: state_d = ST_FETCH;
      ST_FETCH: begin sq_start = 1'b1; state_d = ST_ROOT; end
      ST_ROOT: if (sq_done) state_d = ST_OUT;
      ST_OUT: begin
        if (!out_stall_i) begin
          k_d = k_q + 1'b1;
          state_d = (k_q == pc_q - 1'b1) ? ST_LOAD : ST_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q <= '0; n_q <= '0; i_q <= '0; j_q <= '0; ax_q <= '0;
      pc_q <= '0; k_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; n_q <= n_d; i_q <= i_d; j_q <= j_d; ax_q <= ax_d;
      pc_q <= pc_d; k_q <= k_d;
    end
  end

  // datapath, stores and table
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    dif_q <= da[16] ? 17'(-da) : 17'(da);
    if (acc_in && cnt_q < IdxW'(MaxPoints))
      pts_q[cnt_q[IdxW-1:0]] <= {in_data_i.coord_x, in_data_i.coord_y, in_data_i.coord_z};
    // first compare entry fetched on the last axis, the next one on each shift
    if (state_q == ST_MUL && ax_q == 2'd2 && pc_q != '0) cmp_q <= tbl_q[pc_q - 1'b1];
    if (state_q == ST_INS) begin
      if (ins_shift) begin
        tbl_q[k_q] <= cmp_q;
        if (k_q >= PairW'(2)) cmp_q <= tbl_q[k_q - PairW'(2)];
      end else begin
        tbl_q[k_q] <= newp;
      end
    end
    if (state_q == ST_RD) rd_q <= tbl_q[k_q];
    if (state_q == ST_ROOT && sq_done) begin
      out_q.first_index      <= rd_q.lo;
      out_q.second_index     <= rd_q.hi;
      out_q.squared_distance <= rd_q.sq;
      out_q.distance_fixed   <= root;
      out_q.last_pair        <= (k_q == pc_q - 1'b1);
    end
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = out_q;

  `PDS_ASSERT(a_no_both, clk_i, rst_ni, !(out_valid_o && !in_stall_o), "in and out at once")
  `PDS_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `PDS_ASSERT(a_cnt, clk_i, rst_ni, cnt_q <= IdxW'(MaxPoints), "point count overflow")
endmodule
`default_nettype wire
